FILE: rtl/okvt_pkg.sv
// types and codes shared by the ordered key-value table
// used by ordered_key_value_table_top; no dependencies
package okvt_pkg;

    localparam int FIELD_W = 32;
    localparam int COUNT_W = 5;
    localparam int EXT_W   = 64;

    typedef enum logic [1:0] {
        MODE_DEFINE = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_LIST   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ERASE,
        S_LIST,
        S_OUT
    } t_state;

endpackage

FILE: rtl/okvt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module okvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ordered_key_value_table_top.sv
// ordered key-value table: sequencer and datapath around two key/value rams
// depends on okvt_pkg and okvt_ram
//
// usage:
// the request channel (i_valid / o_stall) carries mode, key and value; a request
// is taken at a clock edge with i_valid high and o_stall low. o_stall stays high
// from the request until its last result has been loaded into the output register.
// the result channel (o_valid / i_stall) carries found, read_value, listed_key,
// entry_count, status and last; a result is taken when o_valid is high and
// i_stall is low. results sit in an output register, so the next request can be
// taken while the final result still waits.
// define, erase and lookup walk the entries one per cycle through the shared
// key compare.
// an erase hit then moves each later entry down one place, one entry per cycle
// through the single ram write port, and then drops the entry count.
// list gives one result per cycle while the receiver does not stall, or one
// empty result on an empty table; the next request is taken once o_stall has
// dropped.
// when the receiver stalls, the output register holds and the sequencer waits
// before it loads its next result.
// reset empties the table at once; entry contents are not cleared.
module ordered_key_value_table_top #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [okvt_pkg::FIELD_W-1:0] i_key,
    input  logic [okvt_pkg::FIELD_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic [okvt_pkg::FIELD_W-1:0] o_read_value,
    output logic [okvt_pkg::FIELD_W-1:0] o_listed_key,
    output logic [okvt_pkg::COUNT_W-1:0] o_entry_count,
    output logic                         o_status,
    output logic                         o_last
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = $clog2(ENTRIES);

    okvt_pkg::t_state r_state, n_state;
    okvt_pkg::t_mode  r_mode, n_mode;

    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [VALUE_BITS-1:0] r_rv, n_rv;
    logic                  r_found, n_found;
    logic                  r_status, n_status;

    logic                         r_out_vld;
    logic                         r_out_found;
    logic [okvt_pkg::FIELD_W-1:0] r_out_rv;
    logic [okvt_pkg::FIELD_W-1:0] r_out_lk;
    logic [okvt_pkg::COUNT_W-1:0] r_out_cnt;
    logic                         r_out_status;
    logic                         r_out_last;

    logic                         out_load;
    logic                         ld_found;
    logic [VALUE_BITS-1:0]        ld_rv;
    logic [KEY_BITS-1:0]          ld_lk;
    logic                         ld_status;
    logic                         ld_last;

    logic                  in_accept;
    logic                  out_free;
    logic                  match;
    logic                  last_idx;
    logic [CW-1:0]         erase_addr;
    logic [KEY_BITS-1:0]   key_in;
    logic [VALUE_BITS-1:0] val_in;

    logic                  key_we, val_we;
    logic [IW-1:0]         waddr;
    logic [KEY_BITS-1:0]   key_wdata, rd_key;
    logic [VALUE_BITS-1:0] val_wdata, rd_val;
    logic [okvt_pkg::EXT_W-1:0] key_in_ext, val_in_ext, lk_ext, rv_ext, cnt_ext;

    okvt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (n_idx[IW-1:0]),
        .o_rdata (rd_key)
    );

    okvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (n_idx[IW-1:0]),
        .o_rdata (rd_val)
    );

    assign in_accept  = i_valid && !o_stall;
    assign out_free   = !r_out_vld || !i_stall;
    assign match      = (rd_key == r_key) && (r_count != '0);
    assign last_idx   = (r_idx == r_count - CW'(1));
    assign erase_addr = r_idx - CW'(1);
    assign key_in_ext = okvt_pkg::EXT_W'(i_key);
    assign val_in_ext = okvt_pkg::EXT_W'(i_value);
    assign key_in     = key_in_ext[KEY_BITS-1:0];
    assign val_in     = val_in_ext[VALUE_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            okvt_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (okvt_pkg::t_mode'(i_mode) == okvt_pkg::MODE_LIST) begin
                        n_state = (r_count == '0) ? okvt_pkg::S_OUT : okvt_pkg::S_LIST;
                    end else begin
                        n_state = okvt_pkg::S_SCAN;
                    end
                end
            end
            okvt_pkg::S_SCAN: begin
                if (match) begin
                    n_state = (r_mode == okvt_pkg::MODE_ERASE) ? okvt_pkg::S_ERASE
                                                               : okvt_pkg::S_OUT;
                end else if (r_count == '0 || last_idx) begin
                    n_state = okvt_pkg::S_OUT;
                end
            end
            okvt_pkg::S_ERASE: begin
                if (r_idx >= r_count) begin
                    n_state = okvt_pkg::S_OUT;
                end
            end
            okvt_pkg::S_LIST: begin
                if (out_free && last_idx) begin
                    n_state = okvt_pkg::S_IDLE;
                end
            end
            okvt_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = okvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = okvt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mode    = r_mode;
        n_key     = r_key;
        n_val     = r_val;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_status  = r_status;
        n_rv      = r_rv;
        key_we    = 1'b0;
        val_we    = 1'b0;
        waddr     = r_idx[IW-1:0];
        key_wdata = r_key;
        val_wdata = r_val;
        out_load  = 1'b0;
        ld_found  = 1'b0;
        ld_rv     = '0;
        ld_lk     = '0;
        ld_status = 1'b0;
        ld_last   = 1'b0;
        case (r_state)
            okvt_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_mode   = okvt_pkg::t_mode'(i_mode);
                    n_key    = key_in;
                    n_val    = val_in;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_status = 1'b0;
                    n_rv     = '0;
                end
            end
            okvt_pkg::S_SCAN: begin
                if (match) begin
                    n_found = 1'b1;
                    case (r_mode)
                        okvt_pkg::MODE_DEFINE: begin
                            val_we = 1'b1;
                        end
                        okvt_pkg::MODE_ERASE: begin
                            n_idx = r_idx + CW'(1);
                        end
                        okvt_pkg::MODE_LOOKUP: begin
                            n_rv = rd_val;
                        end
                        default: begin
                            n_found = 1'b1;
                        end
                    endcase
                end else if (r_count == '0 || last_idx) begin
                    if (r_mode == okvt_pkg::MODE_DEFINE) begin
                        if (r_count < CW'(ENTRIES)) begin
                            key_we  = 1'b1;
                            val_we  = 1'b1;
                            waddr   = r_count[IW-1:0];
                            n_count = r_count + CW'(1);
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            okvt_pkg::S_ERASE: begin
                if (r_idx < r_count) begin
                    // move entry down one place to close the gap
                    key_we    = 1'b1;
                    val_we    = 1'b1;
                    waddr     = erase_addr[IW-1:0];
                    key_wdata = rd_key;
                    val_wdata = rd_val;
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            okvt_pkg::S_LIST: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_found = 1'b1;
                    ld_lk    = rd_key;
                    ld_last  = last_idx;
                    if (!last_idx) begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            okvt_pkg::S_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ld_found  = r_found;
                    ld_rv     = r_rv;
                    ld_status = r_status;
                    ld_last   = 1'b1;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign lk_ext  = okvt_pkg::EXT_W'(ld_lk);
    assign rv_ext  = okvt_pkg::EXT_W'(ld_rv);
    assign cnt_ext = okvt_pkg::EXT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= okvt_pkg::S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= out_load || (r_out_vld && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_status <= n_status;
        r_rv     <= n_rv;
        if (out_load) begin
            r_out_found  <= ld_found;
            r_out_rv     <= rv_ext[okvt_pkg::FIELD_W-1:0];
            r_out_lk     <= lk_ext[okvt_pkg::FIELD_W-1:0];
            r_out_cnt    <= cnt_ext[okvt_pkg::COUNT_W-1:0];
            r_out_status <= ld_status;
            r_out_last   <= ld_last;
        end
    end

    assign o_stall       = (r_state != okvt_pkg::S_IDLE);
    assign o_valid       = r_out_vld;
    assign o_found       = r_out_found;
    assign o_read_value  = r_out_rv;
    assign o_listed_key  = r_out_lk;
    assign o_entry_count = r_out_cnt;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

    // table occupancy stays within its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table depth");

    // a finished erase removes exactly one entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == okvt_pkg::S_ERASE && r_idx >= r_count)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("erase did not drop one entry");

    // listing only walks a non-empty table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == okvt_pkg::S_LIST) |-> (r_count != '0))
        else $error("list walk on empty table");

    // writes never land past the occupied region plus one append slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |-> (CW'(waddr) <= r_count))
        else $error("key write outside table");

endmodule
